### hw/rtl/bgg_pkg.sv
package bgg_pkg;

	localparam int PIX_W      = 8;
	localparam int CFG_W      = 11;
	localparam int ROW_W      = 10;
	localparam int OUT_POS_W  = 10;
	localparam int MIN_DIM    = 3;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
	localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);
	localparam logic [CFG_W-1:0] THRESH_RST = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1,
		CFG_GRAD_THRESH  = 2'd2
	} cfg_idx_t;

	typedef logic [PIX_W-1:0] pix_t;

	// one column of the 3x3 neighborhood, top to bottom
	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} win_col_t;

endpackage

### hw/rtl/blur_with_gradient_gate_3x3.sv
// The transfer of the pixel that completes a window registers it and the line buffer read in
// stage 1; the window logic then loads the output register when stage 1 advances.
// One pixel per cycle unless output stalls; line buffer has one read and one write port.
// Reset clears counters, window, running maximum and config (640 x 480, threshold 0).
// Line buffers are not cleared; they are fully rewritten by the first two rows of a frame.
module blur_with_gradient_gate_3x3
	import bgg_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIX_W-1:0]     pixel,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [OUT_POS_W-1:0] out_row,
	output logic [OUT_POS_W-1:0] out_col,
	output logic [PIX_W-1:0]     value,
	output logic [PIX_W-1:0]     running_max,
	output logic                 frame_done,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int DW = (WW > CFG_W) ? WW : CFG_W;

	// config
	logic [CFG_W-1:0]        fw_q;
	logic [CFG_W-1:0]        fh_q;
	logic signed [CFG_W-1:0] thr_q;

	// input side counters
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [DW-1:0]    w_eff;
	logic [CFG_W-1:0] h_eff;
	logic             last_col;
	logic             last_row;
	logic             acc;

	// stage 1
	logic             v_s1;
	logic             prod_s1;
	logic             fend_s1;
	pix_t             px_s1;
	logic [CW-1:0]    col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             adv_s1;
	logic [2*PIX_W-1:0] lb_rd;

	// window and result
	win_col_t      win_a_q;
	win_col_t      win_b_q;
	win_col_t      win_n;
	pix_t          max_q;
	pix_t          max_n;
	pix_t          blur;
	logic [PIX_W+1:0]  left_sum;
	logic [PIX_W+1:0]  right_sum;
	logic signed [CFG_W:0] grad;
	logic [DW-1:0]  col_m1_ext;
	logic [CW-1:0]  col_m1;
	logic [ROW_W-1:0] row_m1;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= WIDTH_RST;
			fh_q  <= HEIGHT_RST;
			thr_q <= THRESH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  fw_q  <= cfg_wdata;
				CFG_FRAME_HEIGHT: fh_q  <= cfg_wdata;
				CFG_GRAD_THRESH:  thr_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// saturated geometry
	always_comb begin
		if (DW'(fw_q) < DW'(MIN_DIM)) begin
			w_eff = DW'(MIN_DIM);
		end else if (DW'(fw_q) > DW'(MAX_WIDTH)) begin
			w_eff = DW'(MAX_WIDTH);
		end else begin
			w_eff = DW'(fw_q);
		end
		if (fh_q < CFG_W'(MIN_DIM)) begin
			h_eff = CFG_W'(MIN_DIM);
		end else if (fh_q > CFG_W'(MAX_HEIGHT)) begin
			h_eff = CFG_W'(MAX_HEIGHT);
		end else begin
			h_eff = fh_q;
		end
	end

	assign last_col = (DW'(col_q) + DW'(1)) >= w_eff;
	assign last_row = (CFG_W'(row_q) + CFG_W'(1)) >= h_eff;

	// stage 1 can move unless it holds a result and the output register is full and not being taken
	assign adv_s1   = v_s1 & (!prod_s1 | !out_valid | out_ready);
	assign in_ready = !v_s1 | adv_s1;
	assign acc      = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			prod_s1 <= 1'b0;
			fend_s1 <= 1'b0;
		end else if (acc) begin
			v_s1    <= 1'b1;
			prod_s1 <= (row_q >= ROW_W'(2)) && (col_q >= CW'(2));
			fend_s1 <= last_col & last_row;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1  <= pixel;
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
	end

	bgg_line_buf #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (col_q),
		.rd_data (lb_rd),
		.wr_en   (adv_s1),
		.wr_addr (col_s1),
		.wr_data ({lb_rd[PIX_W-1:0], px_s1})
	);

	assign win_n = '{top: lb_rd[2*PIX_W-1:PIX_W], mid: lb_rd[PIX_W-1:0], bot: px_s1};

	// window after the shift: a = left, b = center column, n = right
	always_comb begin
		blur = (win_a_q.top >> 4) + (win_b_q.top >> 3) + (win_n.top >> 4)
		     + (win_a_q.mid >> 3) + (win_b_q.mid >> 2) + (win_n.mid >> 3)
		     + (win_a_q.bot >> 4) + (win_b_q.bot >> 3) + (win_n.bot >> 4);
		left_sum  = (PIX_W+2)'(win_a_q.top) + (PIX_W+2)'(win_a_q.mid)
		          + (PIX_W+2)'(win_a_q.bot);
		right_sum = (PIX_W+2)'(win_n.top) + (PIX_W+2)'(win_n.mid) + (PIX_W+2)'(win_n.bot);
		grad = $signed({2'b00, left_sum}) - $signed({2'b00, right_sum});
		max_n = (win_b_q.mid > max_q) ? win_b_q.mid : max_q;
		col_m1 = col_s1 - CW'(1);
		col_m1_ext = DW'(col_m1);
		row_m1 = row_s1 - ROW_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_a_q <= '0;
			win_b_q <= '0;
			max_q   <= '0;
		end else if (adv_s1) begin
			win_a_q <= win_b_q;
			win_b_q <= win_n;
			if (fend_s1) begin
				max_q <= '0;
			end else if (prod_s1) begin
				max_q <= max_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s1 && prod_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && prod_s1) begin
			out_row     <= row_m1;
			out_col     <= col_m1_ext[OUT_POS_W-1:0];
			value       <= (grad > (CFG_W+1)'(thr_q)) ? blur : '0;
			running_max <= max_n;
			frame_done  <= fend_s1;
		end
	end

`ifndef SYNTH
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && prod_s1 && out_valid && !out_ready)
		else $error("input stalled without a blocked result");

	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_row != '0 && out_col != '0)
		else $error("result for a border pixel");

	a_max_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && fend_s1 |=> max_q == '0)
		else $error("running max not cleared at frame end");

	a_blur_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> value <= PIX_W'(247))
		else $error("blurred value out of range");
`endif

endmodule

### hw/rtl/bgg_line_buf.sv
module bgg_line_buf
	import bgg_pkg::*;
#(
	parameter int DEPTH = MAX_WIDTH_DEF,
	parameter int AW    = $clog2(MAX_WIDTH_DEF)
) (
	input  logic               clk,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output logic [2*PIX_W-1:0] rd_data,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic [2*PIX_W-1:0] wr_data
);

	// {line above, line middle} share one word per column
	logic [2*PIX_W-1:0] mem [DEPTH];
	logic [2*PIX_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	assign rd_data = rd_q;

endmodule
